// ===== rtl/cbm_pkg.sv =====
// ----------------------------------------------------------------------------
// cbm_pkg
// Shared widths and codes for the cartridge bank mapper.
// ----------------------------------------------------------------------------
package cbm_pkg;

  localparam int unsigned ADDR_W     = 16;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned PHYS_W     = 21;
  localparam int unsigned TGT_W      = 3;
  localparam int unsigned KIND_W     = 2;
  localparam int unsigned ROM_BANK_W = 7;
  localparam int unsigned RAM_BANK_W = 2;

  // in_tdata: address, write_data
  localparam int unsigned IN_DATA_W  = 24;
  // out_tdata: phys_address .. divider_reset, padded to whole bytes
  localparam int unsigned OUT_DATA_W = 56;

  // access kinds
  localparam logic ACT_READ  = 1'b0;
  localparam logic ACT_WRITE = 1'b1;

  // target codes
  localparam logic [TGT_W-1:0] TGT_FLAT = 3'd0;
  localparam logic [TGT_W-1:0] TGT_ROM  = 3'd1;
  localparam logic [TGT_W-1:0] TGT_RAM  = 3'd2;
  localparam logic [TGT_W-1:0] TGT_JOY  = 3'd3;
  localparam logic [TGT_W-1:0] TGT_NONE = 3'd4;

  // cartridge kinds
  localparam logic [KIND_W-1:0] KIND_NONE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_MBC1 = 2'd1;
  localparam logic [KIND_W-1:0] KIND_MBC2 = 2'd2;

  // special addresses
  localparam logic [ADDR_W-1:0] ADDR_JOYPAD  = 16'hFF00;
  localparam logic [ADDR_W-1:0] ADDR_DIV     = 16'hFF04;
  localparam logic [ADDR_W-1:0] ADDR_LY      = 16'hFF44;
  localparam logic [ADDR_W-1:0] ADDR_DMA     = 16'hFF46;
  localparam logic [ADDR_W-1:0] ADDR_BOOT    = 16'hFF50;
  localparam logic [ADDR_W-1:0] ADDR_ECHO_LO = 16'hE000;
  localparam logic [ADDR_W-1:0] ADDR_ECHO_HI = 16'hFE00;
  localparam logic [ADDR_W-1:0] ADDR_DROP_LO = 16'hFEA0;
  localparam logic [ADDR_W-1:0] ADDR_DROP_HI = 16'hFEFF;
  localparam logic [ADDR_W-1:0] ADDR_MBC2_RAM_END = 16'hA200;
  localparam logic [ADDR_W-1:0] ECHO_OFFSET  = 16'h2000;

  // output field layout
  typedef struct packed {
    logic                  div_reset;
    logic                  boot_exit;
    logic [ADDR_W-1:0]     mirror_addr;
    logic                  mirror_en;
    logic [BYTE_W-1:0]     wr_value;
    logic                  wr_en;
    logic [PHYS_W-1:0]     phys_addr;
  } result_t;

endpackage

// ===== rtl/cartridge_bank_mapper.sv =====
// ----------------------------------------------------------------------------
// cartridge_bank_mapper
// Maps CPU bus accesses onto flat memory, cartridge ROM/RAM and the joypad,
// keeping MBC1/MBC2 bank state.
// ----------------------------------------------------------------------------
// One bus transaction in, one result out. A transaction is captured in an
// input register, decoded against the bank state and placed in the output
// register, and a new access is taken every cycle while the output side
// keeps up. Bank state changes take effect for the very next access.
// cfg_wr_en/cfg_wr_data load the cartridge kind (0 none, 1 MBC1, 2 MBC2,
// 3 treated as none) and must only be used while no access is in flight.
module cartridge_bank_mapper (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [cbm_pkg::KIND_W-1:0]      cfg_wr_data,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [cbm_pkg::IN_DATA_W-1:0]   in_tdata,   // address[15:0], write_data[23:16]
  input  logic                            in_tuser,   // action
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // phys_address[20:0], write_enable[21], write_value[29:22], mirror_enable[30],
  // mirror_address[46:31], boot_exit[47], divider_reset[48], zero pad[55:49]
  output logic [cbm_pkg::OUT_DATA_W-1:0]  out_tdata,
  output logic [cbm_pkg::TGT_W-1:0]       out_tuser   // target
);

  // configuration and bank state
  logic [cbm_pkg::KIND_W-1:0]     kind_r;
  logic [cbm_pkg::ROM_BANK_W-1:0] rom_bank_r, rom_bank_nxt;
  logic [cbm_pkg::RAM_BANK_W-1:0] ram_bank_r, ram_bank_nxt;
  logic                           ram_en_r, ram_en_nxt;
  logic                           rom_mode_r, rom_mode_nxt;
  logic                           boot_r, boot_nxt;

  // input stage
  logic                           s1_valid_r;
  logic                           s1_act_r;
  logic [cbm_pkg::ADDR_W-1:0]     s1_addr_r;
  logic [cbm_pkg::BYTE_W-1:0]     s1_data_r;

  // output stage
  logic                           out_valid_r;
  logic [cbm_pkg::TGT_W-1:0]      out_tgt_r, out_tgt_nxt;
  cbm_pkg::result_t               out_res_r, out_res_nxt;

  logic s1_adv;
  logic in_fire;
  logic is_mbc1, is_mbc2;
  logic [cbm_pkg::PHYS_W-1:0] ram_phys;
  logic [4:0] lo_bank;

  assign s1_adv    = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || s1_adv;
  assign in_fire   = in_tvalid && in_tready;

  assign is_mbc1 = (kind_r == cbm_pkg::KIND_MBC1);
  assign is_mbc2 = (kind_r == cbm_pkg::KIND_MBC2);

  // window is 0xA000-0xBFFF, so the offset is just the low 13 bits
  assign ram_phys = {{(cbm_pkg::PHYS_W-15){1'b0}}, ram_bank_r, s1_addr_r[12:0]};
  assign lo_bank  = (s1_data_r == '0) ? 5'd1 : s1_data_r[4:0];

  always_comb begin
    out_tgt_nxt  = cbm_pkg::TGT_NONE;
    out_res_nxt  = '0;
    rom_bank_nxt = rom_bank_r;
    ram_bank_nxt = ram_bank_r;
    ram_en_nxt   = ram_en_r;
    rom_mode_nxt = rom_mode_r;
    boot_nxt     = boot_r;

    if (s1_act_r == cbm_pkg::ACT_READ) begin
      if (s1_addr_r[15:14] == 2'b01) begin
        out_tgt_nxt           = cbm_pkg::TGT_ROM;
        out_res_nxt.phys_addr = {rom_bank_r, s1_addr_r[13:0]};
      end else if (s1_addr_r[15:13] == 3'b101) begin
        out_tgt_nxt           = cbm_pkg::TGT_RAM;
        out_res_nxt.phys_addr = ram_phys;
      end else if (s1_addr_r == cbm_pkg::ADDR_JOYPAD) begin
        out_tgt_nxt           = cbm_pkg::TGT_JOY;
        out_res_nxt.phys_addr = {5'd0, s1_addr_r};
      end else begin
        out_tgt_nxt           = cbm_pkg::TGT_FLAT;
        out_res_nxt.phys_addr = {5'd0, s1_addr_r};
      end
    end else if (boot_r) begin
      if (s1_addr_r == cbm_pkg::ADDR_BOOT && s1_data_r == 8'd1) begin
        boot_nxt              = 1'b0;
        out_res_nxt.boot_exit = 1'b1;
      end
      out_tgt_nxt           = cbm_pkg::TGT_FLAT;
      out_res_nxt.phys_addr = {5'd0, s1_addr_r};
      out_res_nxt.wr_en     = 1'b1;
      out_res_nxt.wr_value  = s1_data_r;
    end else if (!s1_addr_r[15]) begin
      // bank register writes, no result target
      case (s1_addr_r[14:13])
        2'd0: begin
          if (is_mbc1 || (is_mbc2 && !s1_addr_r[8])) begin
            if (s1_data_r[3:0] == 4'hA) begin
              ram_en_nxt = 1'b1;
            end else if (s1_data_r == '0) begin
              ram_en_nxt = 1'b0;
            end
          end
        end
        2'd1: begin
          if (is_mbc1) begin
            rom_bank_nxt = {rom_bank_r[6:5], lo_bank};
          end else if (is_mbc2) begin
            rom_bank_nxt = {3'd0, s1_data_r[3:0]};
          end
        end
        2'd2: begin
          if (is_mbc1) begin
            if (rom_mode_r) begin
              ram_bank_nxt = '0;
              // a zero low bank bumps to one
              rom_bank_nxt = {s1_data_r[1:0],
                              rom_bank_r[4:1],
                              rom_bank_r[0] | (rom_bank_r[4:0] == 5'd0)};
            end else begin
              ram_bank_nxt = s1_data_r[1:0];
            end
          end
        end
        default: begin
          if (is_mbc1) begin
            if (s1_data_r[0]) begin
              ram_bank_nxt = '0;
              rom_mode_nxt = 1'b0;
            end else begin
              rom_mode_nxt = 1'b1;
            end
          end
        end
      endcase
    end else if (s1_addr_r[15:13] == 3'b101) begin
      if (ram_en_r && (is_mbc1 ||
          (is_mbc2 && s1_addr_r < cbm_pkg::ADDR_MBC2_RAM_END))) begin
        out_tgt_nxt           = cbm_pkg::TGT_RAM;
        out_res_nxt.phys_addr = ram_phys;
        out_res_nxt.wr_en     = 1'b1;
        out_res_nxt.wr_value  = s1_data_r;
      end
    end else if (s1_addr_r >= cbm_pkg::ADDR_ECHO_LO && s1_addr_r < cbm_pkg::ADDR_ECHO_HI) begin
      out_tgt_nxt             = cbm_pkg::TGT_FLAT;
      out_res_nxt.phys_addr   = {5'd0, s1_addr_r};
      out_res_nxt.wr_en       = 1'b1;
      out_res_nxt.wr_value    = s1_data_r;
      out_res_nxt.mirror_en   = 1'b1;
      out_res_nxt.mirror_addr = s1_addr_r - cbm_pkg::ECHO_OFFSET;
    end else if (s1_addr_r >= cbm_pkg::ADDR_DROP_LO && s1_addr_r <= cbm_pkg::ADDR_DROP_HI) begin
      out_tgt_nxt = cbm_pkg::TGT_NONE;
    end else if (s1_addr_r == cbm_pkg::ADDR_DIV) begin
      out_tgt_nxt           = cbm_pkg::TGT_FLAT;
      out_res_nxt.phys_addr = {5'd0, s1_addr_r};
      out_res_nxt.wr_en     = 1'b1;
      out_res_nxt.div_reset = 1'b1;
    end else if (s1_addr_r == cbm_pkg::ADDR_LY) begin
      out_tgt_nxt           = cbm_pkg::TGT_FLAT;
      out_res_nxt.phys_addr = {5'd0, s1_addr_r};
      out_res_nxt.wr_en     = 1'b1;
    end else if (s1_addr_r == cbm_pkg::ADDR_DMA) begin
      out_tgt_nxt = cbm_pkg::TGT_NONE;
    end else begin
      out_tgt_nxt           = cbm_pkg::TGT_FLAT;
      out_res_nxt.phys_addr = {5'd0, s1_addr_r};
      out_res_nxt.wr_en     = 1'b1;
      out_res_nxt.wr_value  = s1_data_r;
    end
  end

  // control and bank state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r      <= cbm_pkg::KIND_NONE;
      rom_bank_r  <= 7'd1;
      ram_bank_r  <= '0;
      ram_en_r    <= 1'b0;
      rom_mode_r  <= 1'b1;
      boot_r      <= 1'b1;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        kind_r <= cfg_wr_data;
      end
      if (s1_valid_r && s1_adv) begin
        rom_bank_r <= rom_bank_nxt;
        ram_bank_r <= ram_bank_nxt;
        ram_en_r   <= ram_en_nxt;
        rom_mode_r <= rom_mode_nxt;
        boot_r     <= boot_nxt;
      end
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (s1_adv) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_act_r  <= in_tuser;
      s1_addr_r <= in_tdata[15:0];
      s1_data_r <= in_tdata[23:16];
    end
    if (s1_valid_r && s1_adv) begin
      out_tgt_r <= out_tgt_nxt;
      out_res_r <= out_res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_tgt_r;
  assign out_tdata  = {{(cbm_pkg::OUT_DATA_W - $bits(cbm_pkg::result_t)){1'b0}}, out_res_r};

endmodule
